// ===== rtl/pes_pkg.sv =====
// Polygon edge subdivider: shared types and constants.
// Used by the channel interfaces and the top level; no dependencies.
package pes_pkg;

  // Q15.16 coordinates, fixed by the field width
  localparam int CoordW = 32;
  // segment count register width
  localparam int SegW   = 6;
  // divider iteration counter width
  localparam int DivCntW = $clog2(CoordW);

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [SegW-1:0]          seg_t;

  // configuration register indexes
  localparam logic RegSegments = 1'b0;

  // segment count after reset
  localparam seg_t SegReset = seg_t'(3);

endpackage

// ===== rtl/pes_ifs.sv =====
// Polygon edge subdivider: valid/ready channel interfaces for vertex and point words.
// Depends on pes_pkg.
interface pes_vertex_if;
  import pes_pkg::*;

  logic   valid;
  logic   ready;
  coord_t vertex_x;
  coord_t vertex_y;
  logic   closes_polygon;

  modport source (output valid, output vertex_x, output vertex_y, output closes_polygon,
                  input ready);
  modport sink (input valid, input vertex_x, input vertex_y, input closes_polygon,
                output ready);
endinterface

interface pes_point_if;
  import pes_pkg::*;

  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  logic   last_of_run;
  logic   polygon_done;

  modport source (output valid, output point_x, output point_y, output last_of_run,
                  output polygon_done, input ready);
  modport sink (input valid, input point_x, input point_y, input last_of_run,
                input polygon_done, output ready);
endinterface

// ===== rtl/polygon_edge_subdivider.sv =====
// Polygon edge subdivider top level: vertex in, N interpolated points per edge out.
// Depends on pes_pkg and the channel interfaces in pes_ifs.sv.
//
//   channel   dir  word                                              handshake
//   vertex    in   vertex_x, vertex_y, closes_polygon                valid/ready
//   point     out  point_x, point_y, last_of_run, polygon_done       valid/ready
//   apb       in   segments_per_edge at byte address 0               psel/penable
//
// Each edge is divided in the shared restoring divider (x then y), then its
// N points are emitted. A vertex that opens a polygon without closing it
// starts no edge; a vertex that ends one edge runs one, and a closing vertex
// with an open polygon runs two, its edge and the closing edge.
// Reset is synchronous; the block is ready right after.
// vertex.ready is high only between items; a stalled point word holds the
// emit sequencer, and the last word of an item may wait while the next
// vertex is taken.
module polygon_edge_subdivider #(
  parameter int MAX_SEGMENTS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  pes_vertex_if.sink            vertex,
  pes_point_if.source           point,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import pes_pkg::*;

  localparam logic [SegW:0] MaxSegW = (SegW+1)'(MAX_SEGMENTS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t state;

  // configuration
  seg_t segments_per_edge;

  // polygon state
  coord_t first_x, first_y;
  coord_t previous_x, previous_y;
  logic   have_first;

  // edge walk
  coord_t acc_x, acc_y;
  coord_t end_x, end_y;
  coord_t step_x, step_y;
  seg_t   n_eff;
  seg_t   k;
  logic   on_close;
  logic   more;

  // shared divider
  logic               axis;
  logic [DivCntW-1:0] div_cnt;
  logic [CoordW-1:0]  quo;
  seg_t               rem;
  logic               neg;

  // output word register
  logic   out_valid;
  coord_t out_x, out_y;
  logic   out_last, out_done;

  // APB
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegSegments);

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegSegments) begin
      prdata = {{(32-SegW){1'b0}}, segments_per_edge};
    end
  end

  // segment count clamped to 1..MAX_SEGMENTS
  logic [SegW:0] seg_ext;
  seg_t          n_clamp;
  always_comb begin
    seg_ext = {1'b0, segments_per_edge};
    if (segments_per_edge == '0) begin
      n_clamp = seg_t'(1);
    end else if (seg_ext > MaxSegW) begin
      n_clamp = MaxSegW[SegW-1:0];
    end else begin
      n_clamp = segments_per_edge;
    end
  end

  // edge difference and magnitude for the selected axis
  logic signed [CoordW:0] diff;
  logic        [CoordW:0] mag;
  always_comb begin
    if (axis) begin
      diff = {end_y[CoordW-1], end_y} - {acc_y[CoordW-1], acc_y};
    end else begin
      diff = {end_x[CoordW-1], end_x} - {acc_x[CoordW-1], acc_x};
    end
    mag = diff[CoordW] ? -diff : diff;
  end

  // one restoring divide step
  logic [SegW:0]     rem_sh;
  logic [SegW:0]     rem_sub;
  logic              ge;
  logic [CoordW-1:0] q_fin;
  coord_t            step_fin;
  always_comb begin
    rem_sh   = {rem, quo[CoordW-1]};
    rem_sub  = rem_sh - {1'b0, n_eff};
    ge       = rem_sh >= {1'b0, n_eff};
    q_fin    = {quo[CoordW-2:0], ge};
    step_fin = neg ? -coord_t'(q_fin) : coord_t'(q_fin);
  end

  // next point
  coord_t sum_x, sum_y;
  logic   out_free;
  assign sum_x    = acc_x + step_x;
  assign sum_y    = acc_y + step_y;
  assign out_free = !out_valid || point.ready;

  assign vertex.ready       = (state == ST_IDLE);
  assign point.valid        = out_valid;
  assign point.point_x      = out_x;
  assign point.point_y      = out_y;
  assign point.last_of_run  = out_last;
  assign point.polygon_done = out_done;

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      segments_per_edge <= SegReset;
      first_x           <= '0;
      first_y           <= '0;
      previous_x        <= '0;
      previous_y        <= '0;
      have_first        <= 1'b0;
      out_valid         <= 1'b0;
      axis              <= 1'b0;
      div_cnt           <= '0;
      k                 <= '0;
      on_close          <= 1'b0;
      more              <= 1'b0;
    end else begin
      if (cfg_wr) begin
        segments_per_edge <= pwdata[SegW-1:0];
      end
      // in ST_EMIT a free output register is always refilled below
      if (out_valid && point.ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (vertex.valid) begin
            n_eff      <= n_clamp;
            previous_x <= vertex.vertex_x;
            previous_y <= vertex.vertex_y;
            axis       <= 1'b0;
            have_first <= !vertex.closes_polygon;
            if (have_first) begin
              // edge from previous vertex, closing edge may follow
              acc_x    <= previous_x;
              acc_y    <= previous_y;
              end_x    <= vertex.vertex_x;
              end_y    <= vertex.vertex_y;
              on_close <= 1'b0;
              more     <= vertex.closes_polygon;
              state    <= ST_LOAD;
            end else begin
              first_x <= vertex.vertex_x;
              first_y <= vertex.vertex_y;
              // single-vertex polygon: zero-length closing edge
              acc_x    <= vertex.vertex_x;
              acc_y    <= vertex.vertex_y;
              end_x    <= vertex.vertex_x;
              end_y    <= vertex.vertex_y;
              on_close <= 1'b1;
              more     <= 1'b0;
              if (vertex.closes_polygon) begin
                state <= ST_LOAD;
              end
            end
          end
        end

        ST_LOAD: begin
          neg     <= diff[CoordW];
          quo     <= mag[CoordW-1:0];
          rem     <= '0;
          div_cnt <= '0;
          state   <= ST_DIV;
        end

        ST_DIV: begin
          quo     <= q_fin;
          rem     <= ge ? rem_sub[SegW-1:0] : rem_sh[SegW-1:0];
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DivCntW'(CoordW-1)) begin
            if (axis) begin
              step_y <= step_fin;
              k      <= seg_t'(1);
              state  <= ST_EMIT;
            end else begin
              step_x <= step_fin;
              axis   <= 1'b1;
              state  <= ST_LOAD;
            end
          end
        end

        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_x     <= sum_x;
            out_y     <= sum_y;
            out_last  <= (k == n_eff) && !more;
            out_done  <= (k == n_eff) && on_close;
            if (k == n_eff) begin
              if (more) begin
                // closing edge from this vertex back to the first
                acc_x    <= end_x;
                acc_y    <= end_y;
                end_x    <= first_x;
                end_y    <= first_y;
                on_close <= 1'b1;
                more     <= 1'b0;
                axis     <= 1'b0;
                state    <= ST_LOAD;
              end else begin
                state <= ST_IDLE;
              end
            end else begin
              acc_x <= sum_x;
              acc_y <= sum_y;
              k     <= k + 1'b1;
            end
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== verif/polygon_edge_subdivider_test.sv =====
// Testbench for polygon_edge_subdivider: drives vertex words, checks point words
// against an in-bench subdivision predictor, and writes the segment count over APB.
// Depends on pes_pkg, pes_ifs.sv and the polygon_edge_subdivider RTL.
module polygon_edge_subdivider_test;
  import pes_pkg::*;

  localparam int MaxSegments = 32;
  localparam int DrainCycles = 300;   // settling time after both queues are empty
  localparam int StallLimit  = 4000;  // cycles with no word moving on either channel
  localparam int HoldCycles  = 600;   // long receiver hold-off
  localparam int HoldAfter   = 300;   // points taken before the hold-off starts
  localparam coord_t CoordMin = {1'b1, {(CoordW-1){1'b0}}};
  localparam coord_t CoordMax = {1'b0, {(CoordW-1){1'b1}}};

  typedef struct {
    coord_t x;
    coord_t y;
    logic   closes;
  } vertex_word_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
    logic   done;
  } point_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pes_vertex_if vertex_ch();
  pes_point_if  point_ch();

  polygon_edge_subdivider #(
    .MAX_SEGMENTS(MaxSegments)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .vertex  (vertex_ch),
    .point   (point_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // vertices waiting to be offered, points still owed by the block
  vertex_word_t vertex_pending[$];
  point_word_t  expected_points[$];

  // predictor copy of the block's state and register
  coord_t first_x = '0;
  coord_t first_y = '0;
  coord_t prev_x = '0;
  coord_t prev_y = '0;
  logic   have_first = 1'b0;
  seg_t   seg_count = SegReset;

  int  mismatch_count = 0;
  int  points_taken = 0;
  bit  no_idling = 1'b0;
  int  src_gap = 0;
  int  sink_gap = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  quiet_cycles = 0;

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic note_mismatch(input string msg);
    if (mismatch_count < 10) begin
      $display("%s", msg);
    end
    mismatch_count++;
  endtask

  // N points from one edge end toward the other, step truncated toward zero
  function automatic void push_edge(ref point_word_t run[$], input coord_t from_x,
                                    input coord_t from_y, input coord_t to_x,
                                    input coord_t to_y, input int n);
    longint step_x;
    longint step_y;
    point_word_t p;
    step_x = (longint'(to_x) - longint'(from_x)) / longint'(n);
    step_y = (longint'(to_y) - longint'(from_y)) / longint'(n);
    for (int k = 1; k <= n; k++) begin
      p.x = coord_t'(longint'(from_x) + step_x * longint'(k));
      p.y = coord_t'(longint'(from_y) + step_y * longint'(k));
      p.last = 1'b0;
      p.done = 1'b0;
      run.insert(run.size(), p);
    end
  endfunction

  // expected points for one accepted vertex
  function automatic void subdivide_vertex(input vertex_word_t v);
    point_word_t run[$];
    int n;
    n = (seg_count == 0) ? 1 : (int'(seg_count) > MaxSegments) ? MaxSegments : int'(seg_count);
    if (!have_first) begin
      first_x = v.x;
      first_y = v.y;
    end else begin
      push_edge(run, prev_x, prev_y, v.x, v.y, n);
    end
    prev_x = v.x;
    prev_y = v.y;
    if (v.closes) begin
      // closing edge back to the first vertex; zero length on a lone vertex
      push_edge(run, v.x, v.y, first_x, first_y, n);
      run[run.size()-1].done = 1'b1;
      have_first = 1'b0;
    end else begin
      have_first = 1'b1;
    end
    if (run.size() > 0) begin
      run[run.size()-1].last = 1'b1;
    end
    foreach (run[i]) begin
      expected_points.insert(expected_points.size(), run[i]);
    end
  endfunction

  // vertex driver: holds a word until taken, idles in bursts between words
  always @(posedge clk) begin
    if (rst) begin
      vertex_ch.valid <= 1'b0;
      vertex_ch.vertex_x <= '0;
      vertex_ch.vertex_y <= '0;
      vertex_ch.closes_polygon <= 1'b0;
      src_gap = 0;
    end else begin
      if (vertex_ch.valid && vertex_ch.ready) begin
        subdivide_vertex(vertex_pending.pop_front());
      end
      if (vertex_ch.valid && !vertex_ch.ready) begin
        // word still on offer
      end else if (vertex_pending.size() == 0) begin
        vertex_ch.valid <= 1'b0;
      end else if (src_gap > 0 && !no_idling) begin
        src_gap--;
        vertex_ch.valid <= 1'b0;
      end else if (!no_idling && $urandom_range(0, 5) == 0) begin
        src_gap = $urandom_range(0, 14);
        vertex_ch.valid <= 1'b0;
      end else begin
        vertex_ch.valid <= 1'b1;
        vertex_ch.vertex_x <= vertex_pending[0].x;
        vertex_ch.vertex_y <= vertex_pending[0].y;
        vertex_ch.closes_polygon <= vertex_pending[0].closes;
      end
    end
  end

  // point monitor: checks each taken word, stalls in bursts and once for long
  always @(posedge clk) begin
    point_word_t exp_p;
    if (rst) begin
      point_ch.ready <= 1'b0;
    end else begin
      if (point_ch.valid && point_ch.ready) begin
        points_taken++;
        if (expected_points.size() == 0) begin
          note_mismatch($sformatf("point %0d: unexpected word x=%h y=%h last=%b done=%b",
                                  points_taken, point_ch.point_x, point_ch.point_y,
                                  point_ch.last_of_run, point_ch.polygon_done));
        end else begin
          exp_p = expected_points.pop_front();
          if (point_ch.point_x !== exp_p.x || point_ch.point_y !== exp_p.y ||
              point_ch.last_of_run !== exp_p.last || point_ch.polygon_done !== exp_p.done) begin
            note_mismatch($sformatf(
              "point %0d: expected x=%h y=%h last=%b done=%b, got x=%h y=%h last=%b done=%b",
              points_taken, exp_p.x, exp_p.y, exp_p.last, exp_p.done,
              point_ch.point_x, point_ch.point_y, point_ch.last_of_run,
              point_ch.polygon_done));
          end
        end
        if (!hold_done && points_taken == HoldAfter) begin
          hold_left = HoldCycles;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        point_ch.ready <= 1'b0;
      end else if (sink_gap > 0 && !no_idling) begin
        sink_gap--;
        point_ch.ready <= 1'b0;
      end else if (!no_idling && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 14);
        point_ch.ready <= 1'b0;
      end else begin
        point_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on traffic
  always @(posedge clk) begin
    if (rst || (vertex_ch.valid && vertex_ch.ready) || (point_ch.valid && point_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("polygon_edge_subdivider: mismatch");
      $finish;
    end
  end

  // register write, then read back
  task automatic write_segments(input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * RegSegments);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    seg_count = value[SegW-1:0];
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== 32'(seg_count)) begin
      note_mismatch($sformatf("segment count readback: expected %h, got %h",
                              32'(seg_count), prdata));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic push_vertex(input coord_t x, input coord_t y, input logic closes);
    vertex_word_t v;
    v.x = x;
    v.y = y;
    v.closes = closes;
    vertex_pending.insert(vertex_pending.size(), v);
  endtask

  // wait for every owed point, then let an opening vertex finish too
  task automatic settle();
    while (vertex_pending.size() != 0 || expected_points.size() != 0) begin
      @(negedge clk);
    end
    repeat (DrainCycles) @(negedge clk);
  endtask

  function automatic coord_t random_coord();
    coord_t c;
    case ($urandom_range(0, 7))
      0: c = CoordMin;
      1: c = CoordMax;
      2, 3, 4: c = coord_t'($urandom);
      5: c = coord_t'(int'($urandom_range(0, 8191)) - 4096);
      6: begin
        c = coord_t'($urandom >> $urandom_range(1, 31));
        if ($urandom_range(0, 1) == 1) begin
          c = -c;
        end
      end
      default: c = coord_t'(int'($urandom_range(0, 400)) - 200) <<< 16;
    endcase
    return c;
  endfunction

  // whole polygons of random size until about count vertices are queued
  task automatic queue_random_polygons(input int count);
    int queued;
    int sides;
    queued = 0;
    while (queued < count) begin
      sides = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 6);
      for (int i = 0; i < sides; i++) begin
        push_vertex(random_coord(), random_coord(), i == sides - 1);
      end
      queued += sides;
    end
  endtask

  // stimulus sequence
  initial begin
    int seg_plan[7];
    seg_plan = '{5, 32, 1, 12, 63, 7, 2};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset segment count: lone vertex, extreme triangle, small polygon, second lone vertex
    push_vertex('0, '0, 1'b1);
    push_vertex(CoordMin, CoordMin, 1'b0);
    push_vertex(CoordMax, CoordMax, 1'b0);
    push_vertex(CoordMin, CoordMax, 1'b1);
    push_vertex(-1, 1, 1'b0);
    push_vertex(5, -7, 1'b0);
    push_vertex(-196608, 65535, 1'b1);
    push_vertex(CoordMax, CoordMin, 1'b1);
    settle();

    // zero acts as one
    write_segments(32'd0);
    @(negedge clk);
    push_vertex(1, 2, 1'b0);
    push_vertex(3, 4, 1'b0);
    push_vertex(-5, -6, 1'b0);
    push_vertex(7, 8, 1'b1);
    settle();

    // top of the field saturates to the maximum
    write_segments(32'hFFFF_FFFF);
    @(negedge clk);
    push_vertex(CoordMax, CoordMin, 1'b0);
    push_vertex(CoordMin, CoordMax, 1'b1);
    push_vertex(100, -100, 1'b1);
    settle();

    write_segments(32'd33);
    @(negedge clk);
    push_vertex('0, '0, 1'b0);
    push_vertex(-32, 31, 1'b1);
    settle();

    write_segments(32'd1);
    @(negedge clk);
    push_vertex(CoordMin, CoordMin, 1'b0);
    push_vertex(CoordMax, CoordMax, 1'b1);
    settle();

    // random polygons over a range of segment counts, last phase without idling
    foreach (seg_plan[i]) begin
      write_segments(32'(seg_plan[i]));
      @(negedge clk);
      if (i == 6) begin
        no_idling = 1'b1;
      end
      queue_random_polygons(50);
      settle();
    end

    while (expected_points.size() != 0) begin
      void'(expected_points.pop_front());
      note_mismatch("point expected but never produced");
    end
    if (mismatch_count == 0) begin
      $display("polygon_edge_subdivider: match");
    end else begin
      $display("polygon_edge_subdivider: mismatch");
    end
    $finish;
  end

endmodule

// ===== polygon_edge_subdivider.f =====
rtl/pes_pkg.sv
rtl/pes_ifs.sv
rtl/polygon_edge_subdivider.sv
verif/polygon_edge_subdivider_test.sv
